@@ rtl/oph_pkg.sv @@
// Shared codes, widths and control/status bundles for the ordinal pattern histogram.
package oph_pkg;

  localparam int MAX_DIM_DEF     = 5;
  localparam int NUM_BINS_DEF    = 120;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int DIM_BITS   = 3;
  localparam int OP_BITS    = 2;
  localparam int BIN_BITS   = 7;
  localparam int RANK_OUT_W = 7;
  localparam int COUNT_BITS = 32;
  // 8! = 40320 fits in 16 bits
  localparam int RANK_BITS  = 16;

  localparam logic [OP_BITS-1:0] OP_PUSH  = 2'd0;
  localparam logic [OP_BITS-1:0] OP_READ  = 2'd1;
  localparam logic [OP_BITS-1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic accept;     // latch the beat, apply push/clear side effects
    logic rd_bin;     // histogram read at the requested bin
    logic sort_step;  // place one window entry into the sorted order
    logic rank_load;  // register the permutation rank
    logic rd_rank;    // histogram read at the rank
    logic update;     // saturating increment of bin and total
    logic out_load;   // capture the result beat
  } cmd_t;

  typedef struct packed {
    logic [OP_BITS-1:0] in_op;
    logic               push_full;
    logic               sort_last;
    logic               rank_ok;
    logic               out_free;
  } status_t;

endpackage

@@ rtl/oph_ctrl.sv @@
// Sequencer: accept, sort walk, rank, histogram update, result hand-off.
module oph_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  oph_pkg::status_t st,
  output oph_pkg::cmd_t    cmd
);
  import oph_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SORT   = 3'd1;
  localparam logic [2:0] S_RANK   = 3'd2;
  localparam logic [2:0] S_CHECK  = 3'd3;
  localparam logic [2:0] S_UPDATE = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_FINISH;
          if (st.in_op == OP_PUSH && st.push_full) state_next = S_SORT;
          if (st.in_op == OP_READ) cmd.rd_bin = 1'b1;
        end
      end
      S_SORT: begin
        cmd.sort_step = 1'b1;
        if (st.sort_last) state_next = S_RANK;
      end
      S_RANK: begin
        cmd.rank_load = 1'b1;
        state_next    = S_CHECK;
      end
      S_CHECK: begin
        if (st.rank_ok) begin
          cmd.rd_rank = 1'b1;
          state_next  = S_UPDATE;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ rtl/oph_dp.sv @@
// Datapath: sample window, sort walk, rank, histogram memory and result register.
module oph_dp #(
  parameter int MAX_DIM     = oph_pkg::MAX_DIM_DEF,
  parameter int NUM_BINS    = oph_pkg::NUM_BINS_DEF,
  parameter int SAMPLE_BITS = oph_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [oph_pkg::OP_BITS-1:0]          op,
  input  logic signed [SAMPLE_BITS-1:0]        sample,
  input  logic [oph_pkg::BIN_BITS-1:0]         bin,
  input  logic                                 cfg_write,
  input  logic [oph_pkg::DIM_BITS-1:0]         cfg_data,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic                                 pattern_valid,
  output logic [oph_pkg::RANK_OUT_W-1:0]       pattern_rank,
  output logic [oph_pkg::COUNT_BITS-1:0]       bin_count,
  output logic [oph_pkg::COUNT_BITS-1:0]       total_windows,
  input  oph_pkg::cmd_t                        cmd,
  output oph_pkg::status_t                     st
);
  import oph_pkg::*;

  localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CNT_W = $clog2(MAX_DIM + 1);
  localparam int BIN_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  logic [DIM_BITS-1:0]          dim;
  logic signed [SAMPLE_BITS-1:0] win [MAX_DIM];
  logic [IDX_W-1:0]             ord [MAX_DIM];
  logic [CNT_W-1:0]             fill, fill_next;
  logic [CNT_W-1:0]             n;
  logic [IDX_W-1:0]             base;
  logic [IDX_W-1:0]             sidx;
  logic [IDX_W-1:0]             pos;
  logic [RANK_BITS-1:0]         rank;
  logic [OP_BITS-1:0]           op_r;
  logic                         counted;
  logic                         bin_ok;
  logic [COUNT_BITS-1:0]        total;
  logic [COUNT_BITS-1:0]        mem [NUM_BINS];
  logic [NUM_BINS-1:0]          vbits;
  logic [COUNT_BITS-1:0]        rdata;
  logic                         rvalid;
  logic [BIN_W-1:0]             raddr;
  logic [RANK_BITS-1:0]         bin_ext;
  logic [COUNT_BITS-1:0]        old_cnt;

  // Myrvold-Ruskey rank; at most MAX_DIM-1 narrow swap steps
  function automatic logic [RANK_BITS-1:0] mr_rank(input logic [IDX_W-1:0] perm [MAX_DIM],
                                                    input logic [CNT_W-1:0] nn);
    logic [IDX_W-1:0] vec [MAX_DIM];
    logic [IDX_W-1:0] inv [MAX_DIM];
    logic [IDX_W-1:0] lasts [MAX_DIM+1];
    logic [IDX_W-1:0] last, p, t;
    logic [RANK_BITS-1:0] r;
    r = '0;
    for (int i = 0; i < MAX_DIM; i++) begin
      vec[i] = perm[i];
      inv[i] = '0;
    end
    for (int i = 0; i <= MAX_DIM; i++) lasts[i] = '0;
    for (int i = 0; i < MAX_DIM; i++) begin
      if (i < nn) inv[perm[i]] = IDX_W'(i);
    end
    for (int l = MAX_DIM; l >= 2; l--) begin
      if (l <= nn) begin
        last     = vec[l-1];
        p        = inv[l-1];
        lasts[l] = last;
        t        = vec[l-1];
        vec[l-1] = vec[p];
        vec[p]   = t;
        t         = inv[last];
        inv[last] = inv[l-1];
        inv[l-1]  = t;
      end
    end
    for (int l = 2; l <= MAX_DIM; l++) begin
      if (l <= nn) r = RANK_BITS'(lasts[l]) + RANK_BITS'(l) * r;
    end
    return r;
  endfunction

  // effective dimension, clamped to 2..MAX_DIM
  always_comb begin
    if (dim < DIM_BITS'(2))          n = CNT_W'(2);
    else if (int'(dim) > MAX_DIM)    n = CNT_W'(MAX_DIM);
    else                             n = CNT_W'(dim);
    base      = IDX_W'(MAX_DIM - int'(n));
    fill_next = (int'(fill) < MAX_DIM) ? fill + CNT_W'(1) : fill;
  end

  // position of the entry at sidx among the window, older first on ties
  always_comb begin
    pos = '0;
    for (int k = 0; k < MAX_DIM; k++) begin
      if (IDX_W'(k) >= base &&
          (win[k] < win[sidx] || (win[k] == win[sidx] && IDX_W'(k) < sidx)))
        pos = pos + IDX_W'(1);
    end
  end

  assign bin_ext = RANK_BITS'(bin);
  assign raddr   = cmd.rd_bin ? bin_ext[BIN_W-1:0] : rank[BIN_W-1:0];
  assign old_cnt = rvalid ? rdata : '0;

  assign st.in_op     = op;
  assign st.push_full = fill_next >= n;
  assign st.sort_last = sidx == IDX_W'(MAX_DIM - 1);
  assign st.rank_ok   = rank < RANK_BITS'(NUM_BINS);
  assign st.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dim     <= DIM_BITS'(3);
      fill    <= '0;
      total   <= '0;
      vbits   <= '0;
      for (int k = 0; k < MAX_DIM; k++) begin
        win[k] <= '0;
        ord[k] <= '0;
      end
    end else begin
      if (cfg_write) dim <= cfg_data;
      if (cmd.accept && op == OP_PUSH) begin
        for (int k = 0; k + 1 < MAX_DIM; k++) win[k] <= win[k+1];
        win[MAX_DIM-1] <= sample;
        fill           <= fill_next;
      end
      if (cmd.accept && op == OP_CLEAR) begin
        fill  <= '0;
        total <= '0;
        vbits <= '0;
        for (int k = 0; k < MAX_DIM; k++) begin
          win[k] <= '0;
          ord[k] <= '0;
        end
      end
      if (cmd.sort_step) ord[pos] <= sidx - base;
      if (cmd.update) begin
        vbits[rank[BIN_W-1:0]] <= 1'b1;
        if (total != CNT_MAX) total <= total + COUNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r    <= op;
      counted <= (op == OP_PUSH) && st.push_full;
      bin_ok  <= bin_ext < RANK_BITS'(NUM_BINS);
      sidx    <= base;
    end
    if (cmd.sort_step) sidx <= sidx + IDX_W'(1);
    if (cmd.rank_load) rank <= mr_rank(ord, n);
  end

  // histogram store, registered read
  always_ff @(posedge clk) begin
    if (cmd.rd_bin || cmd.rd_rank) begin
      rdata  <= mem[raddr];
      rvalid <= vbits[raddr];
    end
    if (cmd.update)
      mem[rank[BIN_W-1:0]] <= (old_cnt != CNT_MAX) ? old_cnt + COUNT_BITS'(1) : old_cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      pattern_valid <= counted;
      pattern_rank  <= counted ? rank[RANK_OUT_W-1:0] : '0;
      bin_count     <= (op_r == OP_READ && bin_ok) ? old_cnt : '0;
      total_windows <= total;
    end
  end

endmodule

@@ rtl/ordinal_pattern_histogram.sv @@
// Top level: ordinal pattern histogram over a sliding sample window.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+---------------------------------------------
//  input    | in_valid / in_ready   | op, sample, bin
//  result   | out_valid / out_ready | pattern_valid, pattern_rank, bin_count,
//           |                       | total_windows
//  config   | cfg_write             | cfg_data (embed_dim)
//
// One beat in flight. A push with a full window passes through the accept, one sort
// step per window entry, then rank, check with histogram read, write-back and result
// load, where its result is registered. A rank at or beyond the bin count skips the
// write-back. Other beats go from the accept straight to the result load. The
// single-port histogram read-modify-write and the sort walk set the length of a push.
// Reset is synchronous; the histogram store needs no clearing pass, per-bin
// valid flops are cleared by reset and by the clear op. A result waiting on
// out_ready stalls only the final hand-off, and the next beat is taken as soon
// as the previous result is registered.
module ordinal_pattern_histogram #(
  parameter int MAX_DIM     = oph_pkg::MAX_DIM_DEF,
  parameter int NUM_BINS    = oph_pkg::NUM_BINS_DEF,
  parameter int SAMPLE_BITS = oph_pkg::SAMPLE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [oph_pkg::OP_BITS-1:0]    op,
  input  logic signed [SAMPLE_BITS-1:0]  sample,
  input  logic [oph_pkg::BIN_BITS-1:0]   bin,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           pattern_valid,
  output logic [oph_pkg::RANK_OUT_W-1:0] pattern_rank,
  output logic [oph_pkg::COUNT_BITS-1:0] bin_count,
  output logic [oph_pkg::COUNT_BITS-1:0] total_windows,
  input  logic                           cfg_write,
  input  logic [oph_pkg::DIM_BITS-1:0]   cfg_data
);
  import oph_pkg::*;

  cmd_t    cmd;
  status_t st;

  // sequencer
  oph_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // window, sort, rank, histogram and result register
  oph_dp #(
    .MAX_DIM     (MAX_DIM),
    .NUM_BINS    (NUM_BINS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .op            (op),
    .sample        (sample),
    .bin           (bin),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .pattern_valid (pattern_valid),
    .pattern_rank  (pattern_rank),
    .bin_count     (bin_count),
    .total_windows (total_windows),
    .cmd           (cmd),
    .st            (st)
  );

endmodule
